>>> hdl/bsrc_pkg.sv
package bsrc_pkg;

   // Store geometry
   localparam int MAX_BITS  = 4096;
   localparam int WORD_BITS = 64;
   localparam int NUM_WORDS = MAX_BITS / WORD_BITS;
   localparam int WORD_AW   = $clog2(NUM_WORDS);
   localparam int POS_W     = $clog2(WORD_BITS);
   localparam int IDX_W     = $clog2(MAX_BITS);
   localparam int CFG_W     = IDX_W + 1;
   localparam int CMD_W     = 3;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_SET         = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR_BIT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TEST        = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR_RANGE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR_ALL   = 3'd4;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } state_type;

   // Controls for the word merge unit
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
   } merge_ctl_type;

endpackage

>>> hdl/bsrc_ram.sv
module bsrc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bsrc_merge.sv
module bsrc_merge (
   input  bsrc_pkg::merge_ctl_type        ctl,
   input  logic [bsrc_pkg::WORD_BITS-1:0] word_in,
   output logic [bsrc_pkg::WORD_BITS-1:0] word_out,
   output logic                           bit_out
);

   localparam logic [bsrc_pkg::WORD_BITS-1:0] ONES = '1;
   localparam logic [bsrc_pkg::POS_W-1:0] TOP_POS = bsrc_pkg::POS_W'(bsrc_pkg::WORD_BITS - 1);

   logic [bsrc_pkg::WORD_BITS-1:0] upto;
   logic [bsrc_pkg::WORD_BITS-1:0] from;
   logic [bsrc_pkg::WORD_BITS-1:0] span;

   // Mask of in-word positions lo to hi inclusive.
   assign upto = ONES >> (TOP_POS - ctl.hi);
   assign from = ONES << ctl.lo;
   assign span = upto & from;

   // The addressed bit before any change.
   assign bit_out = word_in[ctl.lo];

   // Set ORs the mask in; clear-bit and range clear take it out; other codes pass the word through.
   always_comb begin
      case (ctl.cmd)
         bsrc_pkg::CMD_SET:         word_out = word_in | span;
         bsrc_pkg::CMD_CLEAR_BIT:   word_out = word_in & ~span;
         bsrc_pkg::CMD_CLEAR_RANGE: word_out = word_in & ~span;
         default:                   word_out = word_in;
      endcase
   end

endmodule

>>> hdl/bsrc_ctrl.sv
module bsrc_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   // Command side
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bsrc_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bsrc_pkg::IDX_W-1:0]     req_idx,
   input  logic [bsrc_pkg::IDX_W-1:0]     req_end,
   input  logic [bsrc_pkg::CFG_W-1:0]     lim,
   // Word memory
   output logic                           ram_wr_en,
   output logic [bsrc_pkg::WORD_AW-1:0]   ram_wr_addr,
   output logic [bsrc_pkg::WORD_BITS-1:0] ram_wr_data,
   output logic [bsrc_pkg::WORD_AW-1:0]   ram_rd_addr,
   input  logic [bsrc_pkg::WORD_BITS-1:0] ram_rd_data,
   // Merge unit
   output bsrc_pkg::merge_ctl_type        mrg_ctl,
   output logic [bsrc_pkg::WORD_BITS-1:0] mrg_word_in,
   input  logic [bsrc_pkg::WORD_BITS-1:0] mrg_word_out,
   input  logic                           mrg_bit,
   // Result side
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_value,
   output logic                           rsp_error
);

   localparam int PW = bsrc_pkg::POS_W;
   localparam int AW = bsrc_pkg::WORD_AW;
   localparam int IW = bsrc_pkg::IDX_W;
   localparam int CW = bsrc_pkg::CFG_W;
   localparam int NW = bsrc_pkg::NUM_WORDS;

   bsrc_pkg::state_type state_ff, state_in;

   logic [bsrc_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] ws_ff, ws_in;
   logic [AW-1:0] we_ff, we_in;
   logic [PW-1:0] bs_ff, bs_in;
   logic [PW-1:0] be_ff, be_in;
   logic [NW-1:0] vld_ff, vld_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          res_value_ff, res_value_in;
   logic          res_error_ff, res_error_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_value_ff, rsp_value_in;
   logic          rsp_error_ff, rsp_error_in;

   logic          accept;
   logic          is_bit_cmd;
   logic          is_range_cmd;
   logic          idx_bad;
   logic          end_bad;
   logic          req_err;
   logic          start_walk;
   logic          at_last;
   logic          out_free;
   logic [AW-1:0] req_word;

   // Decode of the offered command
   assign accept       = req_valid && req_ready;
   assign is_bit_cmd   = (req_cmd == bsrc_pkg::CMD_SET) || (req_cmd == bsrc_pkg::CMD_CLEAR_BIT)
                         || (req_cmd == bsrc_pkg::CMD_TEST);
   assign is_range_cmd = (req_cmd == bsrc_pkg::CMD_CLEAR_RANGE);
   assign idx_bad      = {1'b0, req_idx} >= lim;
   assign end_bad      = {1'b0, req_end} >= lim;
   assign req_err      = (is_bit_cmd && idx_bad)
                         || (is_range_cmd && (idx_bad || end_bad || (req_idx > req_end)));
   assign start_walk   = (is_bit_cmd || is_range_cmd) && !req_err;
   assign req_word     = req_idx[IW-1:PW];
   assign at_last      = (cur_ff == we_ff);
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsrc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = start_walk ? bsrc_pkg::ST_WALK : bsrc_pkg::ST_HOLD;
            end
         end
         bsrc_pkg::ST_WALK: begin
            if (at_last) begin
               state_in = bsrc_pkg::ST_HOLD;
            end
         end
         bsrc_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = bsrc_pkg::ST_IDLE;
            end
         end
         default: state_in = bsrc_pkg::ST_IDLE;
      endcase
   end

   // Merge unit controls: partial masks only at the first and last word of a walk
   assign mrg_ctl.cmd  = cmd_ff;
   assign mrg_ctl.lo   = (cur_ff == ws_ff) ? bs_ff : '0;
   assign mrg_ctl.hi   = at_last ? be_ff : '1;
   assign mrg_word_in  = rd_vld_ff ? ram_rd_data : '0;

   // Memory write port: write back the merged word during the walk, except for a test
   assign ram_wr_en   = (state_ff == bsrc_pkg::ST_WALK) && (cmd_ff != bsrc_pkg::CMD_TEST);
   assign ram_wr_addr = cur_ff;
   assign ram_wr_data = mrg_word_out;

   // Datapath and outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      ws_in        = ws_ff;
      we_in        = we_ff;
      bs_in        = bs_ff;
      be_in        = be_ff;
      vld_in       = vld_ff;
      res_value_in = res_value_ff;
      res_error_in = res_error_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      ram_rd_addr  = cur_ff + AW'(1);

      case (state_ff)
         bsrc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            ram_rd_addr = req_word;
            if (accept) begin
               cmd_in       = req_cmd;
               cur_in       = req_word;
               ws_in        = req_word;
               bs_in        = req_idx[PW-1:0];
               we_in        = is_range_cmd ? req_end[IW-1:PW] : req_word;
               be_in        = is_range_cmd ? req_end[PW-1:0] : req_idx[PW-1:0];
               res_value_in = 1'b0;
               res_error_in = req_err;
               // Clear all drops every word that holds a position in use.
               if (req_cmd == bsrc_pkg::CMD_CLEAR_ALL) begin
                  for (int i = 0; i < NW; i++) begin
                     if ((CW'(i) << PW) < lim) begin
                        vld_in[i] = 1'b0;
                     end
                  end
               end
            end
         end
         bsrc_pkg::ST_WALK: begin
            vld_in[cur_ff] = vld_ff[cur_ff] || ram_wr_en;
            cur_in         = cur_ff + AW'(1);
            if (at_last) begin
               res_value_in = (cmd_ff != bsrc_pkg::CMD_CLEAR_RANGE) && mrg_bit;
            end
         end
         bsrc_pkg::ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_error_in = res_error_ff;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase

      rd_vld_in = vld_ff[ram_rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsrc_pkg::ST_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cur_ff       <= cur_in;
      ws_ff        <= ws_in;
      we_ff        <= we_in;
      bs_ff        <= bs_in;
      be_ff        <= be_in;
      rd_vld_ff    <= rd_vld_in;
      res_value_ff <= res_value_in;
      res_error_ff <= res_error_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

endmodule

>>> hdl/bitmap_store_with_range_clear.sv
// Bitmap of up to 4096 bits kept in a 64 x 64-bit word memory, cleared at
// reset through per-word valid flags. Each command transfer yields exactly one
// result transfer. Commands are taken one at a time. A set or clear-bit reads
// and writes back one word and a test only reads it; a range clear walks every
// word it covers; a refused command, a clear all or an unknown code goes
// straight to the result. The word memory reads one word and writes back one
// merged word per cycle during a walk. A finished result sits in the output
// register while the next command is taken. bits_in_use may be written only
// while no command is in progress.
module bitmap_store_with_range_clear (
   input  logic        clock,
   input  logic        reset,
   // Command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [2:0] command, [14:3] position, [26:15] range_end
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] bit_value, [1] error
   // Register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bsrc_pkg::CFG_W-1:0] csr_wdata   // bits_in_use
);

   localparam int IW = bsrc_pkg::IDX_W;
   localparam int CM = bsrc_pkg::CMD_W;
   localparam int CW = bsrc_pkg::CFG_W;

   logic [CW-1:0] bits_in_use_ff, bits_in_use_in;
   logic [CW-1:0] lim;

   logic                           ram_wr_en;
   logic [bsrc_pkg::WORD_AW-1:0]   ram_wr_addr;
   logic [bsrc_pkg::WORD_BITS-1:0] ram_wr_data;
   logic [bsrc_pkg::WORD_AW-1:0]   ram_rd_addr;
   logic [bsrc_pkg::WORD_BITS-1:0] ram_rd_data;

   bsrc_pkg::merge_ctl_type        mrg_ctl;
   logic [bsrc_pkg::WORD_BITS-1:0] mrg_word_in;
   logic [bsrc_pkg::WORD_BITS-1:0] mrg_word_out;
   logic                           mrg_bit;

   logic rsp_value;
   logic rsp_error;

   // Register write: always ready
   assign csr_ready      = 1'b1;
   assign bits_in_use_in = csr_valid ? csr_wdata : bits_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_in_use_ff <= CW'(bsrc_pkg::MAX_BITS);
      end else begin
         bits_in_use_ff <= bits_in_use_in;
      end
   end

   // Positions in use saturate at the store size.
   assign lim = (bits_in_use_ff > CW'(bsrc_pkg::MAX_BITS)) ? CW'(bsrc_pkg::MAX_BITS)
                                                            : bits_in_use_ff;

   bsrc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tdata[CM-1:0]),
      .req_idx     (req_tdata[CM+IW-1:CM]),
      .req_end     (req_tdata[CM+2*IW-1:CM+IW]),
      .lim         (lim),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .mrg_ctl     (mrg_ctl),
      .mrg_word_in (mrg_word_in),
      .mrg_word_out(mrg_word_out),
      .mrg_bit     (mrg_bit),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_value   (rsp_value),
      .rsp_error   (rsp_error)
   );

   bsrc_merge u_merge (
      .ctl     (mrg_ctl),
      .word_in (mrg_word_in),
      .word_out(mrg_word_out),
      .bit_out (mrg_bit)
   );

   bsrc_ram #(
      .WIDTH(bsrc_pkg::WORD_BITS),
      .DEPTH(bsrc_pkg::NUM_WORDS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_tdata = {6'b0, rsp_error, rsp_value};

endmodule

>>> hdl/bsrc_checker.sv
module bsrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A refused command never reports a bit value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("result flags both bit value and error");

   // One command at a time: no transfer in the cycle after a transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command taken while another is in progress");

   // No result is offered straight after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind bitmap_store_with_range_clear bsrc_checker u_bsrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
